/* rtl/bpsm_pkg.sv */
`default_nettype none

package bpsm_pkg;

    // Power state codes
    typedef enum logic [1:0] {
        PS_BATTERY  = 2'd0,
        PS_CHARGED  = 2'd1,
        PS_CHARGING = 2'd2,
        PS_LOWPOWER = 2'd3
    } power_state_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_VOLTAGE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_VOLTAGE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_TIMEOUT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INACTIVITY       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LED_CYCLE        = 3'd5;

    // Register reset values
    localparam logic [12:0] LOW_VOLTAGE_RESET      = 13'd3200;
    localparam logic [12:0] CRITICAL_VOLTAGE_RESET = 13'd3000;
    localparam logic [31:0] LOW_TIMEOUT_RESET      = 32'd5000;
    localparam logic [31:0] CRITICAL_TIMEOUT_RESET = 32'd5000;
    localparam logic [31:0] INACTIVITY_RESET       = 32'd300000;
    localparam logic [15:0] LED_CYCLE_RESET        = 16'd1000;
    localparam logic [15:0] LED_STEP_RESET         = 16'd100;

    // Divide by ten: (x * 52429) >> 19 is exact for any 16-bit x
    localparam logic [16:0] DIV10_RECIP = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    // State reset values
    localparam logic [12:0] LOWEST_MV_RESET  = 13'd6000;
    localparam logic [12:0] HIGHEST_MV_RESET = 13'd0;

    // Charge level table in millivolts
    localparam int          LEVEL_STEPS = 10;
    localparam logic [3:0]  LEVEL_MAX   = 4'd9;
    localparam logic [12:0] CHARGE_TABLE_MV [LEVEL_STEPS] = '{
        13'd3000, 13'd3780, 13'd3830, 13'd3870, 13'd3890,
        13'd3920, 13'd3960, 13'd4000, 13'd4040, 13'd4100
    };

    typedef struct packed {
        logic [12:0] battery_mv;
        logic [31:0] tick_now;
        logic        charging_flag;
        logic        power_good_flag;
        logic [31:0] inactivity_ticks;
    } in_item_t;

    typedef struct packed {
        power_state_t power_state;
        logic         state_changed;
        logic         can_fly;
        logic         restart_radio;
        logic         shutdown_request;
        logic [15:0]  led_on_time;
        logic [15:0]  led_off_time;
        logic [3:0]   charge_level;
        logic [12:0]  voltage_min_mv;
        logic [12:0]  voltage_max_mv;
    } out_item_t;

    // Configuration as seen by the evaluation logic
    typedef struct packed {
        logic [12:0] low_voltage_mv;
        logic [12:0] critical_voltage_mv;
        logic [31:0] low_timeout_ticks;
        logic [31:0] critical_timeout_ticks;
        logic [31:0] inactivity_timeout_ticks;
        logic [15:0] led_cycle_time;
        logic [15:0] led_step;
    } cfg_t;

    // Monitor state carried from item to item
    typedef struct packed {
        logic [31:0]  low_stamp;
        logic [31:0]  critical_stamp;
        power_state_t previous_state;
        logic         flight_allowed;
        logic [12:0]  lowest_mv;
        logic [12:0]  highest_mv;
    } mon_state_t;

endpackage

`default_nettype wire

/* rtl/battery_power_state_monitor.sv */
`default_nettype none
// Result path: input register, then result register, from input accept to result accept.
// Throughput: one item per cycle while results are accepted; the evaluation between the two registers is single pass.
// While a result waits, one more item is taken only if the input register is empty.
// Reset (aresetn low, synchronous): both stages empty, registers to their defaults,
// stamps zero, previous state battery, flight allowed, min 6000 mV, max 0 mV.

module battery_power_state_monitor
    import bpsm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input items
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_item,
    // result items
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_item,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    cfg_t       cfg;
    in_item_t   in_item_reg;
    logic       in_valid_reg;
    out_item_t  out_item_reg;
    logic       out_valid_reg;
    mon_state_t state_reg;
    mon_state_t state_next;
    out_item_t  result;
    logic       advance;
    logic       s_take;

    assign cfg_ready = 1'b1;

    bpsm_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bpsm_eval u_eval (
        .item       (in_item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .result     (result),
        .state_next (state_next)
    );

    // Pipeline flow
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    // Control and monitor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            state_reg.low_stamp      <= 32'd0;
            state_reg.critical_stamp <= 32'd0;
            state_reg.previous_state <= PS_BATTERY;
            state_reg.flight_allowed <= 1'b1;
            state_reg.lowest_mv      <= LOWEST_MV_RESET;
            state_reg.highest_mv     <= HIGHEST_MV_RESET;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

`ifndef ASSERT_OFF
    // No flight permission while on external power
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_item_reg.power_state == PS_CHARGED ||
                          out_item_reg.power_state == PS_CHARGING)
        |-> !out_item_reg.can_fly)
        else $error("can_fly set while on external power");

    // LED times only while charging
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_item_reg.power_state != PS_CHARGING
        |-> out_item_reg.led_on_time == 16'd0 && out_item_reg.led_off_time == 16'd0)
        else $error("LED times outside charging");

    // Radio restart only comes with a state change
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_item_reg.restart_radio |-> out_item_reg.state_changed)
        else $error("radio restart without state change");

    // Monitor state holds its previous state code across a result stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> state_reg.previous_state == $past(state_reg.previous_state))
        else $error("monitor state moved while result stalled");

    // An empty input stage always takes an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire

/* rtl/bpsm_cfg_regs.sv */
`default_nettype none

module bpsm_cfg_regs
    import bpsm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [31:0]            wr_data,
    output cfg_t                        cfg
);

    cfg_t        cfg_reg;
    logic [32:0] recip_prod;

    // LED step = cycle / 10, worked out once when the cycle is written
    assign recip_prod = {17'd0, wr_data[15:0]} * {16'd0, DIV10_RECIP};

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_voltage_mv           <= LOW_VOLTAGE_RESET;
            cfg_reg.critical_voltage_mv      <= CRITICAL_VOLTAGE_RESET;
            cfg_reg.low_timeout_ticks        <= LOW_TIMEOUT_RESET;
            cfg_reg.critical_timeout_ticks   <= CRITICAL_TIMEOUT_RESET;
            cfg_reg.inactivity_timeout_ticks <= INACTIVITY_RESET;
            cfg_reg.led_cycle_time           <= LED_CYCLE_RESET;
            cfg_reg.led_step                 <= LED_STEP_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_LOW_VOLTAGE:      cfg_reg.low_voltage_mv <= wr_data[12:0];
                REG_CRITICAL_VOLTAGE: cfg_reg.critical_voltage_mv <= wr_data[12:0];
                REG_LOW_TIMEOUT:      cfg_reg.low_timeout_ticks <= wr_data;
                REG_CRITICAL_TIMEOUT: cfg_reg.critical_timeout_ticks <= wr_data;
                REG_INACTIVITY:       cfg_reg.inactivity_timeout_ticks <= wr_data;
                REG_LED_CYCLE: begin
                    cfg_reg.led_cycle_time <= wr_data[15:0];
                    cfg_reg.led_step       <= {2'd0, recip_prod[32:DIV10_SHIFT]};
                end
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/bpsm_eval.sv */
`default_nettype none

module bpsm_eval
    import bpsm_pkg::*;
(
    input  wire in_item_t   item,
    input  wire cfg_t       cfg,
    input  wire mon_state_t state,
    output out_item_t       result,
    output mon_state_t      state_next
);

    logic [31:0]  low_stamp_new;
    logic [31:0]  crit_stamp_new;
    logic [31:0]  low_elapsed;
    logic [31:0]  crit_elapsed;
    logic [12:0]  min_new;
    logic [12:0]  max_new;
    power_state_t st;
    logic         changed;
    logic         flight_new;
    logic         radio;
    logic         shut;
    logic [3:0]   level_cnt;
    logic [3:0]   level;
    logic [19:0]  on_prod;
    logic [15:0]  on_t;
    logic [15:0]  off_t;

    // Voltage extremes
    assign min_new = (item.battery_mv < state.lowest_mv)  ? item.battery_mv : state.lowest_mv;
    assign max_new = (item.battery_mv > state.highest_mv) ? item.battery_mv : state.highest_mv;

    // Timestamp refresh above thresholds
    assign low_stamp_new  = (item.battery_mv > cfg.low_voltage_mv) ?
                            item.tick_now : state.low_stamp;
    assign crit_stamp_new = (item.battery_mv > cfg.critical_voltage_mv) ?
                            item.tick_now : state.critical_stamp;
    assign low_elapsed    = item.tick_now - low_stamp_new;
    assign crit_elapsed   = item.tick_now - crit_stamp_new;

    // Classification
    always_comb begin
        if (item.power_good_flag && !item.charging_flag) begin
            st = PS_CHARGED;
        end else if (item.power_good_flag && item.charging_flag) begin
            st = PS_CHARGING;
        end else if (!item.charging_flag && (low_elapsed > cfg.low_timeout_ticks)) begin
            st = PS_LOWPOWER;
        end else begin
            st = PS_BATTERY;
        end
    end

    // State change actions
    assign changed    = (st != state.previous_state);
    assign flight_new = changed ? !(st == PS_CHARGED || st == PS_CHARGING)
                                : state.flight_allowed;
    assign radio      = changed && (st == PS_CHARGING || st == PS_BATTERY);

    // Charge level: table entries strictly below the voltage
    always_comb begin
        level_cnt = 4'd0;
        for (int i = 0; i < LEVEL_STEPS; i++) begin
            level_cnt = level_cnt + {3'd0, (CHARGE_TABLE_MV[i] < item.battery_mv)};
        end
    end
    assign level = (level_cnt > LEVEL_MAX) ? LEVEL_MAX : level_cnt;

    // LED times and shutdown per state
    assign on_prod = {16'd0, level} * {4'd0, cfg.led_step};

    always_comb begin
        on_t  = 16'd0;
        off_t = 16'd0;
        shut  = 1'b0;
        case (st)
            PS_CHARGING: begin
                on_t  = on_prod[15:0];
                off_t = cfg.led_cycle_time - on_prod[15:0];
            end
            PS_LOWPOWER: shut = (crit_elapsed > cfg.critical_timeout_ticks);
            PS_BATTERY:  shut = (item.inactivity_ticks > cfg.inactivity_timeout_ticks);
            default: ;
        endcase
    end

    assign result.power_state      = st;
    assign result.state_changed    = changed;
    assign result.can_fly          = flight_new;
    assign result.restart_radio    = radio;
    assign result.shutdown_request = shut;
    assign result.led_on_time      = on_t;
    assign result.led_off_time     = off_t;
    assign result.charge_level     = level;
    assign result.voltage_min_mv   = min_new;
    assign result.voltage_max_mv   = max_new;

    assign state_next.low_stamp      = low_stamp_new;
    assign state_next.critical_stamp = crit_stamp_new;
    assign state_next.previous_state = st;
    assign state_next.flight_allowed = flight_new;
    assign state_next.lowest_mv      = min_new;
    assign state_next.highest_mv     = max_new;

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb
    import bpsm_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;

    // Indexes past the register file; writes to them must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;

    // Handshake flags from the last rising edge
    logic s_taken   = 1'b0;
    logic cfg_taken = 1'b0;

    // Pending periods and expected status items
    in_item_t  period_q[$];
    out_item_t status_q[$];
    int unsigned queued_periods   = 0;
    int unsigned accepted_periods = 0;
    int unsigned mismatches       = 0;
    int unsigned quiet_cycles     = 0;
    int unsigned send_gap_pct     = 0;
    int unsigned recv_stall_pct   = 0;
    logic [31:0] tick_cursor      = '0;

    // Register mirror
    logic [12:0] low_mv_thr;
    logic [12:0] crit_mv_thr;
    logic [31:0] low_wait;
    logic [31:0] crit_wait;
    logic [31:0] idle_wait;
    logic [15:0] led_period;

    // Monitor state mirror
    logic [31:0]  lo_stamp;
    logic [31:0]  crit_stamp;
    power_state_t last_state;
    logic         fly_ok;
    logic [12:0]  min_seen;
    logic [12:0]  max_seen;

    battery_power_state_monitor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Charge table step k in millivolts
    function automatic logic [12:0] level_mv(input int k);
        case (k)
            0:       level_mv = 13'd3000;
            1:       level_mv = 13'd3780;
            2:       level_mv = 13'd3830;
            3:       level_mv = 13'd3870;
            4:       level_mv = 13'd3890;
            5:       level_mv = 13'd3920;
            6:       level_mv = 13'd3960;
            7:       level_mv = 13'd4000;
            8:       level_mv = 13'd4040;
            default: level_mv = 13'd4100;
        endcase
    endfunction

    function automatic void reset_mirror();
        low_mv_thr  = 13'd3200;
        crit_mv_thr = 13'd3000;
        low_wait    = 32'd5000;
        crit_wait   = 32'd5000;
        idle_wait   = 32'd300000;
        led_period  = 16'd1000;
        lo_stamp    = '0;
        crit_stamp  = '0;
        last_state  = PS_BATTERY;
        fly_ok      = 1'b1;
        min_seen    = 13'd6000;
        max_seen    = 13'd0;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [31:0] val);
        case (idx)
            REG_LOW_VOLTAGE:      low_mv_thr  = val[12:0];
            REG_CRITICAL_VOLTAGE: crit_mv_thr = val[12:0];
            REG_LOW_TIMEOUT:      low_wait    = val;
            REG_CRITICAL_TIMEOUT: crit_wait   = val;
            REG_INACTIVITY:       idle_wait   = val;
            REG_LED_CYCLE:        led_period  = val[15:0];
            default: ;
        endcase
    endfunction

    // Status for one monitoring period; advances the state mirror
    function automatic out_item_t predict_status(input in_item_t p);
        out_item_t    r;
        power_state_t st;
        logic [31:0]  since_low;
        logic [31:0]  since_crit;
        logic [31:0]  on_t;
        logic [3:0]   lvl;
        int           k;
        r = '0;
        if (max_seen < p.battery_mv) max_seen = p.battery_mv;
        if (min_seen > p.battery_mv) min_seen = p.battery_mv;
        if (p.battery_mv > low_mv_thr) lo_stamp = p.tick_now;
        if (p.battery_mv > crit_mv_thr) crit_stamp = p.tick_now;
        since_low  = p.tick_now - lo_stamp;
        since_crit = p.tick_now - crit_stamp;

        // classification
        if (p.power_good_flag && !p.charging_flag) begin
            st = PS_CHARGED;
        end else if (p.power_good_flag) begin
            st = PS_CHARGING;
        end else if (!p.charging_flag && since_low > low_wait) begin
            st = PS_LOWPOWER;
        end else begin
            st = PS_BATTERY;
        end

        // actions on a change
        if (st != last_state) begin
            r.state_changed = 1'b1;
            fly_ok          = (st == PS_LOWPOWER || st == PS_BATTERY);
            r.restart_radio = (st == PS_CHARGING || st == PS_BATTERY);
            last_state      = st;
        end

        lvl = '0;
        for (k = 0; k < 10; k++) begin
            if (level_mv(k) < p.battery_mv) lvl++;
        end
        if (lvl > 4'd9) lvl = 4'd9;

        // actions for the current state
        case (st)
            PS_CHARGING: begin
                on_t           = lvl * (led_period / 10);
                r.led_on_time  = on_t[15:0];
                r.led_off_time = led_period - on_t[15:0];
            end
            PS_LOWPOWER: r.shutdown_request = (since_crit > crit_wait);
            PS_BATTERY:  r.shutdown_request = (p.inactivity_ticks > idle_wait);
            default: ;
        endcase

        r.power_state    = st;
        r.can_fly        = fly_ok;
        r.charge_level   = lvl;
        r.voltage_min_mv = min_seen;
        r.voltage_max_mv = max_seen;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // Driver: periods from the queue, random sender gaps and receiver stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (period_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_item  <= period_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check status items, predict on accepted periods, track writes
    always @(posedge aclk) begin
        out_item_t want;
        s_taken   <= s_valid && s_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: status item expected none actual %h", $time, m_item);
                end else begin
                    want = status_q.pop_front();
                    check_field("power_state", want.power_state, m_item.power_state);
                    check_field("state_changed", want.state_changed, m_item.state_changed);
                    check_field("can_fly", want.can_fly, m_item.can_fly);
                    check_field("restart_radio", want.restart_radio, m_item.restart_radio);
                    check_field("shutdown_request", want.shutdown_request,
                                m_item.shutdown_request);
                    check_field("led_on_time", want.led_on_time, m_item.led_on_time);
                    check_field("led_off_time", want.led_off_time, m_item.led_off_time);
                    check_field("charge_level", want.charge_level, m_item.charge_level);
                    check_field("voltage_min_mv", want.voltage_min_mv,
                                m_item.voltage_min_mv);
                    check_field("voltage_max_mv", want.voltage_max_mv,
                                m_item.voltage_max_mv);
                end
            end
            if (s_valid && s_ready) begin
                status_q.push_back(predict_status(s_item));
                accepted_periods++;
            end
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Watchdog on cycles without any handshake
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge aclk);
        $display("battery_power_state_monitor regression: fail");
        $finish;
    end

    task automatic queue_period(input logic [12:0] mv, input logic [31:0] tick,
                                input logic chg, input logic pg, input logic [31:0] inact);
        in_item_t p;
        p.battery_mv       = mv;
        p.tick_now         = tick;
        p.charging_flag    = chg;
        p.power_good_flag  = pg;
        p.inactivity_ticks = inact;
        period_q.push_back(p);
        queued_periods++;
    endtask

    // Mostly advancing ticks with voltages around thresholds; some pure noise
    task automatic queue_random_periods(input int count);
        logic [12:0] mv;
        logic [31:0] inact;
        logic [31:0] tick_gap;
        logic [1:0]  flags;
        repeat (count) begin
            if ($urandom_range(9) == 0) begin
                tick_cursor = $urandom;
                queue_period(13'($urandom), tick_cursor, 1'($urandom), 1'($urandom),
                             $urandom);
            end else begin
                case ($urandom_range(5))
                    0:       tick_gap = $urandom_range(3);
                    1:       tick_gap = (low_wait >> 2) + $urandom_range(3);
                    2:       tick_gap = (crit_wait >> 2) + $urandom_range(3);
                    3:       tick_gap = low_wait - 1 + $urandom_range(2);
                    4:       tick_gap = crit_wait - 1 + $urandom_range(2);
                    default: tick_gap = $urandom;
                endcase
                tick_cursor += tick_gap;
                case ($urandom_range(5))
                    0:       mv = 13'(low_mv_thr - 13'd2 + $urandom_range(4));
                    1:       mv = 13'(crit_mv_thr - 13'd2 + $urandom_range(4));
                    2:       mv = 13'(level_mv($urandom_range(9)) - 13'd1 + $urandom_range(2));
                    3:       mv = 13'($urandom);
                    4:       mv = $urandom_range(1) ? 13'h1FFF : 13'd0;
                    default: mv = 13'($urandom_range(4300, 2800));
                endcase
                case ($urandom_range(3))
                    0:       inact = idle_wait - 1 + $urandom_range(2);
                    1:       inact = $urandom;
                    2:       inact = $urandom_range(1000);
                    default: inact = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
                endcase
                // battery side dominates so the low-power timers get exercised
                flags = ($urandom_range(9) < 6) ? 2'b00 : 2'($urandom_range(3));
                queue_period(mv, tick_cursor, flags[1], flags[0], inact);
            end
        end
    endtask

    task automatic wait_idle();
        while (accepted_periods != queued_periods || status_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] low_mv, input logic [31:0] crit_mv,
                             input logic [31:0] low_t, input logic [31:0] crit_t,
                             input logic [31:0] idle_t, input logic [31:0] led_t);
        write_reg(REG_LOW_VOLTAGE, low_mv);
        write_reg(REG_CRITICAL_VOLTAGE, crit_mv);
        write_reg(REG_LOW_TIMEOUT, low_t);
        write_reg(REG_CRITICAL_TIMEOUT, crit_t);
        write_reg(REG_INACTIVITY, idle_t);
        write_reg(REG_LED_CYCLE, led_t);
    endtask

    initial begin
        reset_mirror();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed periods on the reset register values
        queue_period(13'd0,    32'd0,         1'b0, 1'b0, 32'd0);
        queue_period(13'h1FFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_period(13'd3500, 32'd100,       1'b0, 1'b1, 32'd0);
        // charging across the table edges
        queue_period(13'd3000, 32'd200,       1'b1, 1'b1, 32'd0);
        queue_period(13'd3001, 32'd210,       1'b1, 1'b1, 32'd0);
        queue_period(13'd3890, 32'd220,       1'b1, 1'b1, 32'd0);
        queue_period(13'd4100, 32'd230,       1'b1, 1'b1, 32'd0);
        queue_period(13'd4101, 32'd240,       1'b1, 1'b1, 32'd0);
        // inactivity at and past its timeout
        queue_period(13'd3500, 32'd1000,      1'b1, 1'b0, 32'd300000);
        queue_period(13'd3500, 32'd1100,      1'b0, 1'b0, 32'd300001);
        // voltage equal to low threshold, elapsed equal then past the timeout
        queue_period(13'd3200, 32'd6000,      1'b0, 1'b0, 32'd0);
        queue_period(13'd3200, 32'd6100,      1'b0, 1'b0, 32'd0);
        queue_period(13'd2500, 32'd6101,      1'b0, 1'b0, 32'd0);
        // critical timeout equal, then expired
        queue_period(13'd2500, 32'd11100,     1'b0, 1'b0, 32'd0);
        queue_period(13'd2500, 32'd11101,     1'b0, 1'b0, 32'd0);
        // charger flag without power good is battery
        queue_period(13'd3000, 32'd11200,     1'b1, 1'b0, 32'd0);
        // tick wraps between stamp and now
        queue_period(13'd3300, 32'hFFFF_FF00, 1'b0, 1'b0, 32'd0);
        queue_period(13'd100,  32'h0000_1000, 1'b0, 1'b0, 32'd0);
        queue_period(13'd100,  32'h0000_1400, 1'b0, 1'b0, 32'd0);
        queue_period(13'd6000, 32'h0000_1500, 1'b1, 1'b1, 32'd0);
        queue_period(13'd6000, 32'h0000_1600, 1'b0, 1'b1, 32'd0);
        wait_idle();

        // Mid-range thresholds, no idling; the queue drains halfway
        write_all(3600, 3300, 20000, 10000, 50000, 1000);
        tick_cursor = 32'h0001_0000;
        queue_random_periods(175);
        wait_idle();
        queue_random_periods(175);
        wait_idle();

        // Everything at its top value, sender gaps
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_gap_pct = 53;
        queue_random_periods(250);
        wait_idle();

        // Everything zero, receiver stalls
        write_all(0, 0, 0, 0, 0, 0);
        send_gap_pct   = 0;
        recv_stall_pct = 53;
        queue_random_periods(250);
        wait_idle();

        // Random register values with junk upper bits, spare indexes, both idle
        write_all($urandom, $urandom, $urandom_range(100000), $urandom_range(100000),
                  $urandom_range(500000), $urandom);
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        send_gap_pct   = 9;
        recv_stall_pct = 9;
        queue_random_periods(400);
        wait_idle();

        // Short timeouts and a tiny LED period, mixed idling
        write_all(3400, 3100, 300, 200, 1000, 9);
        send_gap_pct   = 53;
        recv_stall_pct = 53;
        queue_random_periods(200);
        wait_idle();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        queue_random_periods(200);
        wait_idle();

        repeat (8) @(negedge aclk);
        if (mismatches == 0 && status_q.size() == 0) begin
            $display("battery_power_state_monitor regression: pass");
        end else begin
            $display("battery_power_state_monitor regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/bpsm_pkg.sv
rtl/bpsm_cfg_regs.sv
rtl/bpsm_eval.sv
rtl/battery_power_state_monitor.sv
dv/tb.sv
